FILE: hdl/assert_macros.svh
// Assertion macros shared by the filtered temperature statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hdl/fts_pkg.sv
// Package for the filtered temperature statistics block: field widths,
// register indexes, the queue item and result types, and the divider states.
// No dependencies.
package fts_pkg;

   localparam int YEAR_W      = 14;
   localparam int MONTH_W     = 4;
   localparam int TEMP_W      = 8;
   localparam int COUNT_OUT_W = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_YEAR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MONTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MONTH_MODE   = 2'd2;

   localparam logic [MONTH_W-1:0] TARGET_MONTH_RESET = 4'd1;

   // A classified record as it travels from the front to the back.
   typedef struct packed {
      logic                     matched;
      logic signed [TEMP_W-1:0] temp;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic                      found;
      logic signed [TEMP_W-1:0]  min_temp;
      logic signed [TEMP_W-1:0]  max_temp;
      logic signed [TEMP_W-1:0]  avg_temp;
      logic [COUNT_OUT_W-1:0]    match_count;
   } result_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

FILE: hdl/filtered_temperature_statistics.sv
// Top level of the filtered temperature statistics block.
// Depends on fts_pkg, fts_front, fts_queue, fts_accum and fts_divider.
//
// Records enter one per cycle through a four-entry queue while it is not full;
// the back part takes one record per cycle, but a marked record waits there
// while the divider is busy. On a marked record the back hands the totals to
// a restoring divider that makes one quotient bit per cycle and then loads
// the result register. When no record was kept the division is skipped and
// the divider goes straight from idle to its done state. Unmarked records of
// the next data set keep flowing meanwhile; a further marked record waits
// until the divider is free. One finished result is held on the rsp_ ports
// until it is popped.
module filtered_temperature_statistics #(
   parameter int MAX_RECORDS = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                push,
   output logic                                full,
   input  logic [fts_pkg::YEAR_W-1:0]          req_rec_year,
   input  logic [fts_pkg::MONTH_W-1:0]         req_rec_month,
   input  logic signed [fts_pkg::TEMP_W-1:0]   req_sample_temp,
   input  logic                                req_last_record,
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_found,
   output logic signed [fts_pkg::TEMP_W-1:0]   rsp_min_temp,
   output logic signed [fts_pkg::TEMP_W-1:0]   rsp_max_temp,
   output logic signed [fts_pkg::TEMP_W-1:0]   rsp_avg_temp,
   output logic [fts_pkg::COUNT_OUT_W-1:0]     rsp_match_count
);

   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int SUM_W       = CNT_W + fts_pkg::TEMP_W;
   localparam int QUEUE_DEPTH = 4;

   fts_pkg::item_type                 front_item, head_item;
   fts_pkg::result_type               result;
   logic                              head_valid, head_pop;
   logic                              div_ready, div_start, rsp_valid;
   logic signed [SUM_W-1:0]           div_sum;
   logic [CNT_W-1:0]                  div_count;
   logic signed [fts_pkg::TEMP_W-1:0] div_min, div_max;

   fts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rec_year    (req_rec_year),
      .req_rec_month   (req_rec_month),
      .req_sample_temp (req_sample_temp),
      .req_last_record (req_last_record),
      .item            (front_item)
   );

   fts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   fts_accum #(
      .MAX_RECORDS (MAX_RECORDS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .div_ready  (div_ready),
      .div_start  (div_start),
      .div_sum    (div_sum),
      .div_count  (div_count),
      .div_min    (div_min),
      .div_max    (div_max)
   );

   fts_divider #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .ready     (div_ready),
      .sum_in    (div_sum),
      .count_in  (div_count),
      .min_in    (div_min),
      .max_in    (div_max),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (result)
   );

   assign empty           = !rsp_valid;
   assign rsp_found       = result.found;
   assign rsp_min_temp    = result.min_temp;
   assign rsp_max_temp    = result.max_temp;
   assign rsp_avg_temp    = result.avg_temp;
   assign rsp_match_count = result.match_count;

endmodule

FILE: hdl/fts_front.sv
// Front part: configuration registers and classification of each request.
// Depends on fts_pkg.
module fts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [fts_pkg::YEAR_W-1:0]          req_rec_year,
   input  logic [fts_pkg::MONTH_W-1:0]         req_rec_month,
   input  logic signed [fts_pkg::TEMP_W-1:0]   req_sample_temp,
   input  logic                                req_last_record,
   output fts_pkg::item_type                   item
);

   logic [fts_pkg::YEAR_W-1:0]  target_year_ff,  target_year_in;
   logic [fts_pkg::MONTH_W-1:0] target_month_ff, target_month_in;
   logic                        month_mode_ff,   month_mode_in;

   always_comb begin
      target_year_in  = target_year_ff;
      target_month_in = target_month_ff;
      month_mode_in   = month_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            fts_pkg::CSR_TARGET_YEAR:  target_year_in  = csr_wdata[fts_pkg::YEAR_W-1:0];
            fts_pkg::CSR_TARGET_MONTH: target_month_in = csr_wdata[fts_pkg::MONTH_W-1:0];
            fts_pkg::CSR_MONTH_MODE:   month_mode_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_year_ff  <= '0;
         target_month_ff <= fts_pkg::TARGET_MONTH_RESET;
         month_mode_ff   <= 1'b0;
      end else begin
         target_year_ff  <= target_year_in;
         target_month_ff <= target_month_in;
         month_mode_ff   <= month_mode_in;
      end
   end

   always_comb begin
      item.matched = (req_rec_year == target_year_ff) &&
                     (!month_mode_ff || (req_rec_month == target_month_ff));
      item.temp    = req_sample_temp;
      item.last    = req_last_record;
   end

endmodule

FILE: hdl/fts_queue.sv
// Short queue of classified records between the front and the back part.
// Depends on fts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fts_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fts_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output fts_pkg::item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fts_pkg::item_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic               do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH), "queue count overflow")
   `ASSERT_ALWAYS(a_queue_push, clock, reset, (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)), "accepted request not stored")
   `ASSERT_NEVER(a_queue_ptrs, clock, reset, (cnt_ff == '0) && (wr_ptr_ff != rd_ptr_ff), "empty queue with unequal pointers")

endmodule

FILE: hdl/fts_accum.sv
// Back part: count, sum, minimum and maximum of the kept records.
// Hands the totals of a data set to the divider on the marked record.
// Depends on fts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fts_accum #(
   parameter int MAX_RECORDS = 65536,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  fts_pkg::item_type                 head_item,
   output logic                              head_pop,
   input  logic                              div_ready,
   output logic                              div_start,
   output logic signed [SUM_W-1:0]           div_sum,
   output logic [CNT_W-1:0]                  div_count,
   output logic signed [fts_pkg::TEMP_W-1:0] div_min,
   output logic signed [fts_pkg::TEMP_W-1:0] div_max
);

   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]           sum_ff, sum_in;
   logic signed [fts_pkg::TEMP_W-1:0] min_ff, min_in;
   logic signed [fts_pkg::TEMP_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0]                  cnt_upd;
   logic signed [SUM_W-1:0]           sum_upd;
   logic signed [fts_pkg::TEMP_W-1:0] min_upd, max_upd;
   logic                              take, keep;

   // A marked record waits here until the divider is free.
   assign take     = head_valid && (!head_item.last || div_ready);
   assign head_pop = take;
   assign keep     = head_item.matched && (cnt_ff < CNT_W'(MAX_RECORDS));

   always_comb begin
      cnt_upd = cnt_ff;
      sum_upd = sum_ff;
      min_upd = min_ff;
      max_upd = max_ff;
      if (keep) begin
         cnt_upd = cnt_ff + CNT_W'(1);
         sum_upd = sum_ff + SUM_W'(head_item.temp);
         if (cnt_ff == '0) begin
            min_upd = head_item.temp;
            max_upd = head_item.temp;
         end else begin
            if (head_item.temp < min_ff) min_upd = head_item.temp;
            if (head_item.temp > max_ff) max_upd = head_item.temp;
         end
      end
   end

   assign div_start = take && head_item.last;
   assign div_sum   = sum_upd;
   assign div_count = cnt_upd;
   assign div_min   = min_upd;
   assign div_max   = max_upd;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (take) begin
         if (head_item.last) begin
            cnt_in = '0;
            sum_in = '0;
            min_in = '0;
            max_in = '0;
         end else begin
            cnt_in = cnt_upd;
            sum_in = sum_upd;
            min_in = min_upd;
            max_in = max_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   `ASSERT_ALWAYS(a_accum_bound, clock, reset, cnt_ff <= CNT_W'(MAX_RECORDS), "kept count beyond limit")
   `ASSERT_ALWAYS(a_accum_start, clock, reset, div_start |-> div_ready, "divider started while busy")
   `ASSERT_ALWAYS(a_accum_order, clock, reset, (cnt_ff != '0) |-> (min_ff <= max_ff), "minimum above maximum")

endmodule

FILE: hdl/fts_divider.sv
// Back part: restoring divider for the average and the result register.
// One quotient bit per cycle; depends on fts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fts_divider #(
   parameter int CNT_W = 17,
   parameter int SUM_W = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              ready,
   input  logic signed [SUM_W-1:0]           sum_in,
   input  logic [CNT_W-1:0]                  count_in,
   input  logic signed [fts_pkg::TEMP_W-1:0] min_in,
   input  logic signed [fts_pkg::TEMP_W-1:0] max_in,
   input  logic                              rsp_pop,
   output logic                              rsp_valid,
   output fts_pkg::result_type               rsp_data
);

   localparam int MAG_W  = SUM_W - 1;
   localparam int STEP_W = $clog2(MAG_W);
   localparam int TW     = fts_pkg::TEMP_W;

   fts_pkg::div_state_type   state_ff, state_in;
   logic [MAG_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic signed [TW-1:0]     min_ff, min_in_r;
   logic signed [TW-1:0]     max_ff, max_in_r;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     out_valid_ff, out_valid_in;
   fts_pkg::result_type      out_ff, out_in;

   logic [CNT_W:0]           rem_shift, rem_diff;
   logic                     fits;
   logic [MAG_W-1:0]         abs_sum;
   logic [TW-1:0]            quo_low;
   logic                     found;

   assign rem_shift = {rem_ff, quo_ff[MAG_W-1]};
   assign fits      = (rem_shift >= {1'b0, div_ff});
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign abs_sum   = sum_in[SUM_W-1] ? MAG_W'(-sum_in) : MAG_W'(sum_in);
   assign quo_low   = quo_ff[TW-1:0];
   assign found     = (div_ff != '0);

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      min_in_r     = min_ff;
      max_in_r     = max_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      ready        = 1'b0;
      unique case (state_ff)
         fts_pkg::DIV_IDLE: begin
            ready = 1'b1;
            if (start) begin
               quo_in   = abs_sum;
               rem_in   = '0;
               div_in   = count_in;
               neg_in   = sum_in[SUM_W-1];
               min_in_r = min_in;
               max_in_r = max_in;
               step_in  = STEP_W'(MAG_W - 1);
               // With nothing kept all totals are zero, so the division is skipped.
               state_in = (count_in == '0) ? fts_pkg::DIV_DONE : fts_pkg::DIV_RUN;
            end
         end
         fts_pkg::DIV_RUN: begin
            rem_in = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], fits};
            if (step_ff == '0) begin
               state_in = fts_pkg::DIV_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         fts_pkg::DIV_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in.found       = found;
               out_in.min_temp    = min_ff;
               out_in.max_temp    = max_ff;
               out_in.avg_temp    = neg_ff ? TW'(~quo_low + TW'(1)) : quo_low;
               out_in.match_count = fts_pkg::COUNT_OUT_W'(div_ff);
               out_valid_in       = 1'b1;
               state_in           = fts_pkg::DIV_IDLE;
            end
         end
         default: state_in = fts_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::DIV_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      min_ff <= min_in_r;
      max_ff <= max_in_r;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `ASSERT_ALWAYS(a_div_nonzero, clock, reset, (state_ff == fts_pkg::DIV_RUN) |-> (div_ff != '0), "division by zero count")
   `ASSERT_ALWAYS(a_div_hold, clock, reset, (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_ff)), "waiting result overwritten")
   `ASSERT_ALWAYS(a_div_rem, clock, reset, (state_ff == fts_pkg::DIV_RUN) |-> (rem_ff < div_ff), "remainder not below divisor")

endmodule
